### hw/rtl/nnt_pkg.sv
// Package: shared constants, codes and control structs of the nearest-neighbour tour core.
`timescale 1ns / 1ps

package nnt_pkg;

   localparam int MAX_CITIES = 16;
   localparam int CITY_W     = $clog2(MAX_CITIES);
   localparam int COUNT_W    = $clog2(MAX_CITIES + 1);
   localparam int ADDR_W     = 2 * CITY_W;
   localparam int DEPTH      = MAX_CITIES * MAX_CITIES;
   localparam int WEIGHT_W   = 25;
   localparam int SUM_W      = 28;
   localparam int CSR_W      = 5;
   localparam int CSR_IDX_W  = 1;

   localparam logic signed [WEIGHT_W-1:0] WEIGHT_LIMIT = 25'sd9999999;
   localparam logic signed [WEIGHT_W-1:0] ABSENT_EDGE  = -25'sd1;
   localparam logic [SUM_W-1:0]           SUM_MAX      = {SUM_W{1'b1}};
   localparam logic [COUNT_W-1:0]         NUM_RESET    = COUNT_W'(MAX_CITIES);
   localparam logic [COUNT_W-1:0]         NUM_MIN      = COUNT_W'(2);
   localparam logic [COUNT_W-1:0]         NUM_MAX      = COUNT_W'(MAX_CITIES);

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_RUN   = 1'b1
   } nnt_op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_CITIES = 1'b0,
      CSR_START_CITY = 1'b1
   } nnt_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } nnt_state_type;

   typedef struct packed {
      logic write_entry;
      logic start_run;
      logic scan_col;
      logic commit_step;
   } nnt_cmd_type;

   typedef struct packed {
      logic out_free;
      logic col_last;
      logic step_last;
   } nnt_stat_type;

endpackage

### hw/rtl/nnt_if.sv
// Interfaces: request and response channels of the nearest-neighbour tour core.
`timescale 1ns / 1ps

interface nnt_req_if;
   import nnt_pkg::*;
   logic                       valid;
   logic                       ready;
   logic                       opcode;
   logic [3:0]                 row_city;
   logic [3:0]                 col_city;
   logic signed [WEIGHT_W-1:0] edge_weight;

   modport source (output valid, output opcode, output row_city, output col_city,
                   output edge_weight, input ready);
   modport sink   (input valid, input opcode, input row_city, input col_city,
                   input edge_weight, output ready);
endinterface

interface nnt_rsp_if;
   import nnt_pkg::*;
   logic             valid;
   logic             ready;
   logic [3:0]       tour_city;
   logic [SUM_W-1:0] total_distance;
   logic             last;
   logic             missing_edge;

   modport source (output valid, output tour_city, output total_distance, output last,
                   output missing_edge, input ready);
   modport sink   (input valid, input tour_city, input total_distance, input last,
                   input missing_edge, output ready);
endinterface

### hw/rtl/nnt_ctrl.sv
// Controller: sequences matrix writes and the column scans of a tour.
`timescale 1ns / 1ps

module nnt_ctrl
   import nnt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_opcode,
   output logic         req_ready,
   input  nnt_stat_type stat,
   output nnt_cmd_type  cmd
);

   nnt_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_opcode == OP_RUN) begin
                  state_in = ST_START;
               end else begin
                  cmd.write_entry = 1'b1;
               end
            end
         end
         ST_START: begin
            if (stat.out_free) begin
               cmd.start_run = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_col = 1'b1;
            if (stat.col_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (stat.out_free) begin
               cmd.commit_step = 1'b1;
               state_in        = stat.step_last ? ST_IDLE : ST_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### hw/rtl/nnt_datapath.sv
// Datapath: weight memory, scan compare, tour state, running sum and result register.
`timescale 1ns / 1ps

module nnt_datapath
   import nnt_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  nnt_cmd_type                cmd,
   output nnt_stat_type               stat,
   input  logic [CITY_W-1:0]          wr_row,
   input  logic [CITY_W-1:0]          wr_col,
   input  logic signed [WEIGHT_W-1:0] wr_weight,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_W-1:0]           csr_wdata,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic [CITY_W-1:0]          rsp_city,
   output logic [SUM_W-1:0]           rsp_sum,
   output logic                       rsp_last,
   output logic                       rsp_miss
);

   logic signed [WEIGHT_W-1:0] weights [DEPTH];

   logic [COUNT_W-1:0]         num_ff;
   logic [CITY_W-1:0]          start_ff;
   logic [COUNT_W-1:0]         n_ff;
   logic [CITY_W-1:0]          s_ff;
   logic [CITY_W-1:0]          cur_ff;
   logic [MAX_CITIES-1:0]      visited_ff;
   logic [CITY_W-1:0]          col_ff;
   logic [COUNT_W-1:0]         step_ff;
   logic [SUM_W-1:0]           sum_ff;
   logic signed [WEIGHT_W-1:0] rd_data_ff;
   logic [CITY_W-1:0]          rd_col_ff;
   logic                       rd_vld_ff;
   logic signed [WEIGHT_W-1:0] best_ff;
   logic [CITY_W-1:0]          best_col_ff;
   logic                       found_ff;
   logic signed [WEIGHT_W-1:0] ret_ff;
   logic                       out_vld_ff;
   logic [CITY_W-1:0]          out_city_ff;
   logic [SUM_W-1:0]           out_sum_ff;
   logic                       out_last_ff;
   logic                       out_miss_ff;

   logic [COUNT_W-1:0]         n_calc;
   logic [CITY_W-1:0]          s_calc;
   logic                       take;
   logic                       found_eff;
   logic [CITY_W-1:0]          next_city;
   logic signed [WEIGHT_W-1:0] add_w;
   logic [SUM_W:0]             sum_wide;
   logic [SUM_W-1:0]           sum_next;
   logic                       miss_next;

   // Clamp the city count and fall back to city 0 for an out-of-range start.
   always_comb begin
      if (num_ff > NUM_MAX) begin
         n_calc = NUM_MAX;
      end else if (num_ff < NUM_MIN) begin
         n_calc = NUM_MIN;
      end else begin
         n_calc = num_ff;
      end
      s_calc = ({1'b0, start_ff} >= n_calc) ? '0 : start_ff;
   end

   assign take = rd_vld_ff && !visited_ff[rd_col_ff] && (rd_data_ff > ABSENT_EDGE)
                 && (rd_data_ff < best_ff);

   always_comb begin
      found_eff = found_ff && !stat.step_last;
      next_city = found_eff ? best_col_ff : s_ff;
      miss_next = !found_eff && ret_ff[WEIGHT_W-1];
      if (found_eff) begin
         add_w = best_ff;
      end else if (ret_ff[WEIGHT_W-1]) begin
         add_w = '0;
      end else begin
         add_w = ret_ff;
      end
      sum_wide = {1'b0, sum_ff} + (SUM_W+1)'(add_w[WEIGHT_W-2:0]);
      sum_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
   end

   assign stat.out_free  = !out_vld_ff || rsp_ready;
   assign stat.col_last  = ({1'b0, col_ff} == (n_ff - COUNT_W'(1)));
   assign stat.step_last = (step_ff == n_ff);

   // Weight memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.write_entry) begin
         weights[{wr_row, wr_col}] <= wr_weight;
      end
      rd_data_ff <= weights[{cur_ff, col_ff}];
      rd_col_ff  <= col_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff     <= NUM_RESET;
         start_ff   <= '0;
         rd_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         cur_ff     <= '0;
         visited_ff <= '0;
         step_ff    <= '0;
         sum_ff     <= '0;
         col_ff     <= '0;
         n_ff       <= NUM_MIN;
         s_ff       <= '0;
         found_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_NUM_CITIES: num_ff   <= csr_wdata;
               CSR_START_CITY: start_ff <= csr_wdata[CITY_W-1:0];
               default: ;
            endcase
         end
         rd_vld_ff <= cmd.scan_col;
         if (cmd.scan_col) begin
            col_ff <= col_ff + CITY_W'(1);
         end
         if (take) begin
            found_ff <= 1'b1;
         end
         if (cmd.start_run) begin
            n_ff       <= n_calc;
            s_ff       <= s_calc;
            cur_ff     <= s_calc;
            visited_ff <= MAX_CITIES'(1) << s_calc;
            step_ff    <= COUNT_W'(1);
            sum_ff     <= '0;
            col_ff     <= '0;
            found_ff   <= 1'b0;
         end
         if (cmd.commit_step) begin
            cur_ff  <= next_city;
            sum_ff  <= sum_next;
            step_ff <= step_ff + COUNT_W'(1);
            col_ff  <= '0;
            found_ff <= 1'b0;
            if (found_eff) begin
               visited_ff[best_col_ff] <= 1'b1;
            end
         end
         if (cmd.start_run || cmd.commit_step) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // Scan statistics and result payload.
   always_ff @(posedge clock) begin
      if (take) begin
         best_ff     <= rd_data_ff;
         best_col_ff <= rd_col_ff;
      end
      if (rd_vld_ff && (rd_col_ff == s_ff)) begin
         ret_ff <= rd_data_ff;
      end
      if (cmd.start_run || cmd.commit_step) begin
         best_ff <= WEIGHT_LIMIT;
      end
      if (cmd.start_run) begin
         out_city_ff <= s_calc;
         out_sum_ff  <= '0;
         out_last_ff <= 1'b0;
         out_miss_ff <= 1'b0;
      end else if (cmd.commit_step) begin
         out_city_ff <= next_city;
         out_sum_ff  <= sum_next;
         out_last_ff <= stat.step_last;
         out_miss_ff <= miss_next;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_city  = out_city_ff;
   assign rsp_sum   = out_sum_ff;
   assign rsp_last  = out_last_ff;
   assign rsp_miss  = out_miss_ff;

endmodule

### hw/rtl/nearest_neighbour_tour_core.sv
// Top level: greedy nearest-neighbour tour core over a weighted adjacency matrix.
`timescale 1ns / 1ps

// A write item stores one matrix entry; an entry of -1 (or any negative value) marks a
// missing edge, and every entry read by a tour must have been written first.
// A run item builds a tour from the start city and returns n+1 items, n being num_cities
// clamped to 2..16: the start city with a zero sum, then one city per step with the
// running distance, the last item being the return to the start city and carrying the
// tour total. Each step scans the current city's row one column per cycle through the
// single read port of the weight memory, and a response-side stall holds the step's
// commit. No item is taken while a tour is in progress; configuration writes are taken
// at any time and should be made while the core is idle.

module nearest_neighbour_tour_core
   import nnt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   nnt_req_if.sink              req_ch,
   nnt_rsp_if.source            rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   nnt_cmd_type  cmd;
   nnt_stat_type stat;

   // The controller owns the handshake on the request side and drives the datapath.
   nnt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_opcode (req_ch.opcode),
      .req_ready  (req_ch.ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // The datapath holds the matrix, the tour state and the output register, so a
   // finished item waits there while the scan of the next step goes on.
   nnt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .wr_row    (req_ch.row_city),
      .wr_col    (req_ch.col_city),
      .wr_weight (req_ch.edge_weight),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_city  (rsp_ch.tour_city),
      .rsp_sum   (rsp_ch.total_distance),
      .rsp_last  (rsp_ch.last),
      .rsp_miss  (rsp_ch.missing_edge)
   );

endmodule

### hw/rtl/nnt_checker.sv
// Checker: port-level assertions for the nearest-neighbour tour core, bound to the top level.
`timescale 1ns / 1ps

module nnt_checker
   import nnt_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             req_opcode,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [3:0]       rsp_city,
   input logic [SUM_W-1:0] rsp_sum,
   input logic             rsp_last
);

   // Nothing is offered on the response side straight after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled item holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_city) && $stable(rsp_sum)
                                     && $stable(rsp_last)))
      else $error("stalled response item changed");

   // While a tour is still being delivered, no request is taken.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> !req_ready)
      else $error("request accepted during a tour");

   // Accepting a run item closes the request side on the next cycle.
   a_run_closes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_opcode == OP_RUN)) |=> !req_ready)
      else $error("request side open after a run item");

endmodule

bind nearest_neighbour_tour_core nnt_checker u_nnt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .req_opcode (req_ch.opcode),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_city   (rsp_ch.tour_city),
   .rsp_sum    (rsp_ch.total_distance),
   .rsp_last   (rsp_ch.last)
);
